### design/seeded_box_position_sampler_core_defines.svh
// Assertion macros for the seeded box position sampler checker.
// No dependencies; included by the checker file only.
`ifndef SEEDED_BOX_POSITION_SAMPLER_CORE_DEFINES_SVH
`define SEEDED_BOX_POSITION_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on aclk.
`define SBPS_ASSERT_IMPL(lbl, dis, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (dis) (ante) |-> (cons)) \
        else $error("sbps check failed");

// Next-cycle implication, clocked on aclk.
`define SBPS_ASSERT_NEXT(lbl, dis, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (dis) (ante) |=> (cons)) \
        else $error("sbps check failed");

`endif

### design/sbps_pkg.sv
// Shared types and constants of the seeded box position sampler.
// No dependencies.
`default_nettype none

package sbps_pkg;

    localparam int unsigned COORD_W  = 32;
    localparam int unsigned EXT_W    = 31;
    localparam int unsigned INDEX_W  = 32;
    localparam int unsigned STATE_W  = 64;
    localparam int unsigned FRAC_W   = 53;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam int unsigned MIX_LAT   = 5;
    localparam int unsigned SCALE_LAT = 3;
    localparam int unsigned PIPE_LAT  = MIX_LAT + SCALE_LAT;

    localparam logic [STATE_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [STATE_W-1:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [STATE_W-1:0] MIX_MUL_B    = 64'h94D049BB133111EB;

    localparam logic [STATE_W-1:0] GAMMA_X = GOLDEN_GAMMA;
    localparam logic [STATE_W-1:0] GAMMA_Y = GOLDEN_GAMMA + GOLDEN_GAMMA;
    localparam logic [STATE_W-1:0] GAMMA_Z = GAMMA_Y + GOLDEN_GAMMA;

    localparam logic [CFG_IDX_W-1:0] REG_SEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 3'd6;

    // Only the low seed word reaches the state: (seed << 32) mod 2^64.
    typedef struct packed {
        logic [31:0]        seed_lo;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] center_z;
        logic [EXT_W-1:0]   extent_x;
        logic [EXT_W-1:0]   extent_y;
        logic [EXT_W-1:0]   extent_z;
    } cfg_t;

endpackage

`default_nettype wire

### design/seeded_box_position_sampler_core.sv
// Top level of the seeded box position sampler: config registers, three mix lanes,
// three scale lanes, valid and index pipeline. Depends on sbps_pkg, sbps_cfg, sbps_mix and sbps_scale.
// Pipeline: 5 mix stages, then 3 scale stages, from input beat to result beat.
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or taken, so a stall holds every stage in place.
// Reset: synchronous, active low; clears valid bits and config registers to zero.
`default_nettype none

module seeded_box_position_sampler_core
    import sbps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [INDEX_W-1:0]    s_sample_index,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [INDEX_W-1:0]    m_index_out,
    output logic      [COORD_W-1:0]    m_pos_x,
    output logic      [COORD_W-1:0]    m_pos_y,
    output logic      [COORD_W-1:0]    m_pos_z
);

    cfg_t                cfg;
    logic                en;
    logic [STATE_W-1:0]  base;
    logic [FRAC_W-1:0]   frac_x, frac_y, frac_z;

    logic [PIPE_LAT-1:0] valid_reg, valid_next;
    logic [INDEX_W-1:0]  idx_reg [PIPE_LAT];

    sbps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready = 1'b1;
    assign en        = !valid_reg[PIPE_LAT-1] || m_ready;
    assign s_ready   = en;
    assign base      = {cfg.seed_lo, s_sample_index};

    sbps_mix u_mix_x (.aclk(aclk), .en(en), .base(base), .offset(GAMMA_X), .frac(frac_x));
    sbps_mix u_mix_y (.aclk(aclk), .en(en), .base(base), .offset(GAMMA_Y), .frac(frac_y));
    sbps_mix u_mix_z (.aclk(aclk), .en(en), .base(base), .offset(GAMMA_Z), .frac(frac_z));

    sbps_scale u_scale_x (
        .aclk(aclk), .en(en), .frac(frac_x),
        .extent(cfg.extent_x), .center(cfg.center_x), .pos(m_pos_x)
    );
    sbps_scale u_scale_y (
        .aclk(aclk), .en(en), .frac(frac_y),
        .extent(cfg.extent_y), .center(cfg.center_y), .pos(m_pos_y)
    );
    sbps_scale u_scale_z (
        .aclk(aclk), .en(en), .frac(frac_z),
        .extent(cfg.extent_z), .center(cfg.center_z), .pos(m_pos_z)
    );

    assign valid_next = {valid_reg[PIPE_LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg[0] <= s_sample_index;
            for (int i = 1; i < PIPE_LAT; i++) begin
                idx_reg[i] <= idx_reg[i-1];
            end
        end
    end

    assign m_valid     = valid_reg[PIPE_LAT-1];
    assign m_index_out = idx_reg[PIPE_LAT-1];

endmodule

`default_nettype wire

### design/sbps_cfg.sv
// Configuration register file of the seeded box position sampler.
// Depends on sbps_pkg.
`default_nettype none

module sbps_cfg
    import sbps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SEED:     cfg_next.seed_lo  = cfg_data[31:0];
                REG_CENTER_X: cfg_next.center_x = cfg_data[COORD_W-1:0];
                REG_CENTER_Y: cfg_next.center_y = cfg_data[COORD_W-1:0];
                REG_CENTER_Z: cfg_next.center_z = cfg_data[COORD_W-1:0];
                REG_EXTENT_X: cfg_next.extent_x = cfg_data[EXT_W-1:0];
                REG_EXTENT_Y: cfg_next.extent_y = cfg_data[EXT_W-1:0];
                REG_EXTENT_Z: cfg_next.extent_z = cfg_data[EXT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/sbps_mix.sv
// One splitmix64 lane: state offset, two split 64-bit multiplies, top 53 bits out.
// Five register stages. Depends on sbps_pkg.
`default_nettype none

module sbps_mix
    import sbps_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [STATE_W-1:0] base,
    input  wire logic [STATE_W-1:0] offset,
    output logic      [FRAC_W-1:0]  frac
);

    logic [STATE_W-1:0] st;
    logic [STATE_W-1:0] z1;
    logic [STATE_W-1:0] z2;

    logic [STATE_W-1:0] u_reg, u_next;
    logic [63:0]        a_ll_reg, a_ll_next;
    logic [31:0]        a_lh_reg, a_lh_next;
    logic [31:0]        a_hl_reg, a_hl_next;
    logic [STATE_W-1:0] v_reg, v_next;
    logic [63:0]        b_ll_reg, b_ll_next;
    logic [31:0]        b_lh_reg, b_lh_next;
    logic [31:0]        b_hl_reg, b_hl_next;
    logic [FRAC_W-1:0]  m_reg, m_next;

    always_comb begin
        st        = base + offset;
        u_next    = st ^ (st >> 30);

        a_ll_next = 64'(u_reg[31:0]) * 64'(MIX_MUL_A[31:0]);
        a_lh_next = 32'(u_reg[31:0] * MIX_MUL_A[63:32]);
        a_hl_next = 32'(u_reg[63:32] * MIX_MUL_A[31:0]);

        z1        = a_ll_reg + {a_lh_reg + a_hl_reg, 32'b0};
        v_next    = z1 ^ (z1 >> 27);

        b_ll_next = 64'(v_reg[31:0]) * 64'(MIX_MUL_B[31:0]);
        b_lh_next = 32'(v_reg[31:0] * MIX_MUL_B[63:32]);
        b_hl_next = 32'(v_reg[63:32] * MIX_MUL_B[31:0]);

        z2        = b_ll_reg + {b_lh_reg + b_hl_reg, 32'b0};
        m_next    = FRAC_W'((z2 ^ (z2 >> 31)) >> (STATE_W - FRAC_W));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg    <= u_next;
            a_ll_reg <= a_ll_next;
            a_lh_reg <= a_lh_next;
            a_hl_reg <= a_hl_next;
            v_reg    <= v_next;
            b_ll_reg <= b_ll_next;
            b_lh_reg <= b_lh_next;
            b_hl_reg <= b_hl_next;
            m_reg    <= m_next;
        end
    end

    assign frac = m_reg;

endmodule

`default_nettype wire

### design/sbps_scale.sv
// Fraction times extent, floor, then center minus half extent plus offset.
// Three register stages. Depends on sbps_pkg.
`default_nettype none

module sbps_scale
    import sbps_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [FRAC_W-1:0]  frac,
    input  wire logic [EXT_W-1:0]   extent,
    input  wire logic [COORD_W-1:0] center,
    output logic      [COORD_W-1:0] pos
);

    localparam int unsigned HI_W  = FRAC_W - 32 + EXT_W;
    localparam int unsigned LO_W  = 32 + EXT_W;
    localparam int unsigned ACC_W = HI_W + 1;

    logic [HI_W-1:0]    hi_reg, hi_next;
    logic [LO_W-1:0]    lo_reg, lo_next;
    logic [ACC_W-1:0]   acc;
    logic [COORD_W-1:0] off_reg, off_next;
    logic [COORD_W-1:0] pos_reg, pos_next;

    always_comb begin
        hi_next  = HI_W'(frac[FRAC_W-1:32]) * HI_W'(extent);
        lo_next  = LO_W'(frac[31:0]) * LO_W'(extent);
        acc      = ACC_W'(hi_reg) + ACC_W'(lo_reg[LO_W-1:32]);
        off_next = COORD_W'(acc >> (FRAC_W - 32));
        pos_next = center - COORD_W'(extent >> 1) + off_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_reg  <= hi_next;
            lo_reg  <= lo_next;
            off_reg <= off_next;
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

### design/sbps_checker.sv
// Port-level checks for seeded_box_position_sampler_core, bound to the top level.
// Depends on sbps_pkg and seeded_box_position_sampler_core_defines.svh.
`default_nettype none

`include "seeded_box_position_sampler_core_defines.svh"

module sbps_checker
    import sbps_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [INDEX_W-1:0] m_index_out,
    input wire logic [COORD_W-1:0] m_pos_x,
    input wire logic [COORD_W-1:0] m_pos_y,
    input wire logic [COORD_W-1:0] m_pos_z
);

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    `SBPS_ASSERT_NEXT(a_reset_empties, 1'b0, !aresetn, !m_valid)
    `SBPS_ASSERT_NEXT(a_out_hold, !aresetn, m_valid && !m_ready, m_valid && $stable(m_index_out) && $stable(m_pos_x) && $stable(m_pos_y) && $stable(m_pos_z))
    `SBPS_ASSERT_IMPL(a_stall_blocks_in, !aresetn, m_valid && !m_ready, !s_fire)
    `SBPS_ASSERT_IMPL(a_free_takes_in, !aresetn, !m_valid, s_ready)

endmodule

bind seeded_box_position_sampler_core sbps_checker u_sbps_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_index_out (m_index_out),
    .m_pos_x     (m_pos_x),
    .m_pos_y     (m_pos_y),
    .m_pos_z     (m_pos_z)
);

`default_nettype wire

### tb/tb_seeded_box_position_sampler_core.sv
// Self-checking bench for seeded_box_position_sampler_core: checks that each sampled position
// matches a splitmix64 box-sampling predictor, under random input gaps and output stalls.
// Depends on sbps_pkg and the core RTL.
module tb_seeded_box_position_sampler_core;
    import sbps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_BEATS = 160;

    typedef struct packed {
        logic [INDEX_W-1:0] sample_idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } position_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_QUARTER,
        READY_BURSTY
    } stall_mode_t;

    class position_scoreboard;
        logic [STATE_W-1:0] seed;
        logic [COORD_W-1:0] center_x, center_y, center_z;
        logic [EXT_W-1:0]   extent_x, extent_y, extent_z;
        position_t          expected_q[$];
        int                 fail_count;

        function new();
            seed = '0;
            center_x = '0;
            center_y = '0;
            center_z = '0;
            extent_x = '0;
            extent_y = '0;
            extent_z = '0;
            fail_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SEED:     seed = data;
                REG_CENTER_X: center_x = data[COORD_W-1:0];
                REG_CENTER_Y: center_y = data[COORD_W-1:0];
                REG_CENTER_Z: center_z = data[COORD_W-1:0];
                REG_EXTENT_X: extent_x = data[EXT_W-1:0];
                REG_EXTENT_Y: extent_y = data[EXT_W-1:0];
                REG_EXTENT_Z: extent_z = data[EXT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [STATE_W-1:0] mix_output(logic [STATE_W-1:0] st);
            logic [STATE_W-1:0] z;
            z = st;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            return z ^ (z >> 31);
        endfunction

        // center - floor(extent/2) + floor(frac * extent), frac = top 53 bits / 2^53
        function logic [COORD_W-1:0] place(logic [STATE_W-1:0] r, logic [COORD_W-1:0] ctr,
                                           logic [EXT_W-1:0] ext);
            logic [83:0]        prod;
            logic [COORD_W-1:0] half;
            logic [COORD_W-1:0] offset;
            prod   = {31'b0, r[63:11]} * {53'b0, ext};
            half   = {2'b0, ext[EXT_W-1:1]};
            offset = {1'b0, prod[83:53]};
            return ctr - half + offset;
        endfunction

        function void note_index(logic [INDEX_W-1:0] k);
            logic [STATE_W-1:0] st;
            position_t          pos;
            st = (seed << 32) + {32'b0, k};
            pos.sample_idx = k;
            st = st + GOLDEN_GAMMA;
            pos.x = place(mix_output(st), center_x, extent_x);
            st = st + GOLDEN_GAMMA;
            pos.y = place(mix_output(st), center_y, extent_y);
            st = st + GOLDEN_GAMMA;
            pos.z = place(mix_output(st), center_z, extent_z);
            expected_q.insert(expected_q.size(), pos);
        endfunction

        function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
            fail_count++;
        endfunction

        function void check_result(logic [INDEX_W-1:0] idx, logic [COORD_W-1:0] x,
                                   logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
            position_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat, index", idx, '0);
                return;
            end
            want = expected_q.pop_front();
            if (idx !== want.sample_idx) report_mismatch("index_out", idx, want.sample_idx);
            if (x !== want.x) report_mismatch("pos_x", x, want.x);
            if (y !== want.y) report_mismatch("pos_y", y, want.y);
            if (z !== want.z) report_mismatch("pos_z", z, want.z);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [INDEX_W-1:0]    s_sample_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [INDEX_W-1:0]    m_index_out;
    logic [COORD_W-1:0]    m_pos_x;
    logic [COORD_W-1:0]    m_pos_y;
    logic [COORD_W-1:0]    m_pos_z;

    position_scoreboard sb = new();

    stall_mode_t stall_mode = READY_ALWAYS;
    int unsigned mode_left = 0;
    int unsigned tick = 0;
    int unsigned cycle_count = 0;

    seeded_box_position_sampler_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_index (s_sample_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_index_out    (m_index_out),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_pos_z        (m_pos_z)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: check accepted beats, then pick next ready per stall mode
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_index_out, m_pos_x, m_pos_y, m_pos_z);
        end
        tick <= tick + 1;
        if (mode_left == 0) begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(40, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            READY_ALWAYS:  m_ready <= 1'b1;
            READY_COIN:    m_ready <= $urandom_range(0, 1);
            READY_QUARTER: m_ready <= (tick[1:0] == 2'd0);
            default:       m_ready <= ((tick % 24) >= 14);
        endcase
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // upper data bits are junk on purpose; the block must drop them
    task automatic load_box(input logic [STATE_W-1:0] seed,
                            input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                            input logic [COORD_W-1:0] cz, input logic [EXT_W-1:0] ex,
                            input logic [EXT_W-1:0] ey, input logic [EXT_W-1:0] ez);
        write_reg(REG_SEED, seed);
        write_reg(REG_CENTER_X, {$urandom, cx});
        write_reg(REG_CENTER_Y, {$urandom, cy});
        write_reg(REG_CENTER_Z, {$urandom, cz});
        write_reg(REG_EXTENT_X, {$urandom, 1'($urandom), ex});
        write_reg(REG_EXTENT_Y, {$urandom, 1'($urandom), ey});
        write_reg(REG_EXTENT_Z, {$urandom, 1'($urandom), ez});
        write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_index(input logic [INDEX_W-1:0] k);
        s_valid        <= 1'b1;
        s_sample_index <= k;
        do @(posedge aclk); while (!s_ready);
        sb.note_index(k);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    task automatic send_corners();
        logic [INDEX_W-1:0] corner_idx [6];
        corner_idx = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA};
        foreach (corner_idx[i]) send_index(corner_idx[i]);
        s_valid <= 1'b0;
        wait_idle();
    endtask

    function automatic logic [INDEX_W-1:0] pick_index();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 15);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            2:       return 32'h1 << $urandom_range(0, 31);
            3:       return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_center();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [EXT_W-1:0] pick_extent();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return EXT_W'($urandom_range(1, 255));
            3:       return EXT_W'($urandom_range(1, 32'h0001_0000));
            default: return EXT_W'($urandom);
        endcase
    endfunction

    task automatic run_random_phase(input int n, input int hold_at);
        int burst_left;
        int gap;
        burst_left = 0;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) begin
                s_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            if (burst_left > 0) burst_left--;
            send_index(pick_index());
        end
        s_valid <= 1'b0;
        wait_idle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: zero extents put every coordinate on the origin
        send_corners();
        // largest box at the top center: coordinates wrap
        load_box(64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_corners();
        // odd and tiny extents at the bottom center; seed high word drops out
        load_box(64'h0000_0001_0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 31'd1, 31'd3, 31'd2);
        send_corners();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_box({$urandom, $urandom}, pick_center(), pick_center(), pick_center(),
                     pick_extent(), pick_extent(), pick_extent());
            run_random_phase(PHASE_BEATS, (p == 2) ? PHASE_BEATS / 2 : -1);
        end

        if (sb.pending() != 0) begin
            sb.report_mismatch("beats never delivered", sb.pending(), '0);
        end
        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
